@@ rtl/drs_pkg.sv @@
// Shared constants, codes and types for the disk request scheduler.
// No dependencies; imported by every module of the block.
package drs_pkg;

    localparam int MAX_REQUESTS = 32;
    localparam int IDX_W        = $clog2(MAX_REQUESTS);
    localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
    localparam int CYL_W        = 16;
    localparam int TRAVEL_W     = 24;
    localparam logic [TRAVEL_W-1:0] TRAVEL_MAX = {TRAVEL_W{1'b1}};

    // Configuration register indexes.
    localparam logic [1:0] REG_POLICY   = 2'd0;
    localparam logic [1:0] REG_START    = 2'd1;
    localparam logic [1:0] REG_TOP      = 2'd2;

    // Service policies.
    localparam logic [1:0] POL_FCFS     = 2'd0;
    localparam logic [1:0] POL_SSTF     = 2'd1;
    localparam logic [1:0] POL_SCAN     = 2'd2;
    localparam logic [1:0] POL_CSCAN    = 2'd3;

    // Selection rules applied by the compare unit during one pass.
    localparam logic [2:0] SEL_FIRST     = 3'd0;
    localparam logic [2:0] SEL_NEAR      = 3'd1;
    localparam logic [2:0] SEL_BELOW_MAX = 3'd2;
    localparam logic [2:0] SEL_MIN       = 3'd3;
    localparam logic [2:0] SEL_MAX       = 3'd4;

    // Running best candidate of a selection pass.
    typedef struct packed {
        logic             have;
        logic [CYL_W-1:0] val;
        logic [CYL_W-1:0] key;
    } drs_best_t;

endpackage

@@ rtl/drs_store.sv @@
// Request store: one write port and one registered read port.
// Depends on drs_pkg for widths and depth.
module drs_store
    import drs_pkg::*;
(
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [CYL_W-1:0] wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [CYL_W-1:0] rd_data
);

    logic [CYL_W-1:0] mem [MAX_REQUESTS];
    logic [CYL_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/drs_select.sv @@
// Compare unit: decides whether a stored request beats the best one so far.
// Depends on drs_pkg for selection codes and the best-candidate struct.
module drs_select
    import drs_pkg::*;
(
    input  logic [2:0]       sel_mode,
    input  logic [CYL_W-1:0] head,
    input  logic [CYL_W-1:0] cand,
    input  drs_best_t        best,
    output logic             take,
    output logic [CYL_W-1:0] cand_key
);

    // Absolute seek distance from the head.
    assign cand_key = (cand > head) ? (cand - head) : (head - cand);

    always_comb begin
        case (sel_mode)
            SEL_FIRST:     take = !best.have;
            SEL_NEAR:      take = !best.have || (cand_key < best.key);
            SEL_BELOW_MAX: take = (cand <= head) && (!best.have || (cand > best.val));
            SEL_MIN:       take = !best.have || (cand < best.val);
            SEL_MAX:       take = !best.have || (cand > best.val);
            default:       take = 1'b0;
        endcase
    end

endmodule

@@ rtl/disk_request_scheduler.sv @@
// Disk request scheduler: loads a batch of requests, then emits them in order.
// Loading accepts one word per cycle. Each served word takes one pass of the compare unit
// over the n stored requests through the store read port, a decide state and an output
// state; the pass is repeated when the sweep turns at 0.
// Reset is synchronous, active low; it empties the batch and loads register defaults.
// Depends on drs_pkg, drs_store and drs_select.
module disk_request_scheduler
    import drs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [CYL_W-1:0]    cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CYL_W-1:0]    s_request_cylinder,
    input  logic                s_last_request,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CYL_W-1:0]    m_served_cylinder,
    output logic [TRAVEL_W-1:0] m_total_travel,
    output logic                m_last_served
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_OUT    = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          policy_reg;
    logic [CYL_W-1:0]    start_reg;
    logic [CYL_W-1:0]    top_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    served_reg;
    logic [CNT_W-1:0]    addr_reg;
    logic [MAX_REQUESTS-1:0] marks_reg;
    logic                phase_reg;
    logic [CYL_W-1:0]    head_reg;
    logic [TRAVEL_W-1:0] travel_reg;
    logic                rd_vld_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    drs_best_t           best_reg;
    drs_best_t           best_next;
    logic [IDX_W-1:0]    best_idx_reg;
    logic                out_last_reg;
    logic [CYL_W-1:0]    out_cyl_reg;

    logic                in_fire;
    logic [CYL_W-1:0]    rd_data;
    logic [2:0]          sel_mode;
    logic                take;
    logic [CYL_W-1:0]    cand_key;
    logic [CYL_W-1:0]    move_to;
    logic [CYL_W-1:0]    move_dist;
    logic [TRAVEL_W:0]   move_sum;
    logic [TRAVEL_W-1:0] travel_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_fire = s_valid && s_ready;

    drs_store u_store (
        .aclk    (aclk),
        .wr_en   (in_fire && (count_reg < CNT_W'(MAX_REQUESTS))),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (s_request_cylinder),
        .rd_addr (addr_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // Pick the selection rule for this pass from policy and sweep phase.
    always_comb begin
        case (policy_reg)
            POL_FCFS:  sel_mode = SEL_FIRST;
            POL_SSTF:  sel_mode = SEL_NEAR;
            POL_SCAN:  sel_mode = phase_reg ? SEL_MIN : SEL_BELOW_MAX;
            POL_CSCAN: sel_mode = phase_reg ? SEL_MAX : SEL_BELOW_MAX;
            default:   sel_mode = SEL_FIRST;
        endcase
    end

    drs_select u_select (
        .sel_mode (sel_mode),
        .head     (head_reg),
        .cand     (rd_data),
        .best     (best_reg),
        .take     (take),
        .cand_key (cand_key)
    );

    always_comb begin
        best_next = best_reg;
        if (rd_vld_reg && !marks_reg[rd_idx_reg] && take) begin
            best_next.have = 1'b1;
            best_next.val  = rd_data;
            best_next.key  = cand_key;
        end
    end

    // Head movement with saturating travel; target is the pick or cylinder 0.
    assign move_to     = best_reg.have ? best_reg.val : '0;
    assign move_dist   = (move_to > head_reg) ? (move_to - head_reg) : (head_reg - move_to);
    assign move_sum    = {1'b0, travel_reg} + (TRAVEL_W + 1)'(move_dist);
    assign travel_next = move_sum[TRAVEL_W] ? TRAVEL_MAX : move_sum[TRAVEL_W-1:0];

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= POL_FCFS;
            start_reg  <= '0;
            top_reg    <= '1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_POLICY: policy_reg <= cfg_wdata[1:0];
                REG_START:  start_reg  <= cfg_wdata;
                REG_TOP:    top_reg    <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // Sequencer: load, scan the store, act on the pick, hand out one word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            served_reg <= '0;
            addr_reg   <= '0;
            marks_reg  <= '0;
            phase_reg  <= 1'b0;
            rd_vld_reg <= 1'b0;
            travel_reg <= '0;
            best_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        if (count_reg < CNT_W'(MAX_REQUESTS)) begin
                            count_reg <= count_reg + 1'b1;
                        end
                        if (s_last_request) begin
                            head_reg   <= start_reg;
                            travel_reg <= '0;
                            phase_reg  <= 1'b0;
                            served_reg <= '0;
                            addr_reg   <= '0;
                            rd_vld_reg <= 1'b0;
                            best_reg   <= '0;
                            state_reg  <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    best_reg <= best_next;
                    if (best_next != best_reg) begin
                        best_idx_reg <= rd_idx_reg;
                    end
                    if (addr_reg < count_reg) begin
                        rd_idx_reg <= addr_reg[IDX_W-1:0];
                        rd_vld_reg <= 1'b1;
                        addr_reg   <= addr_reg + 1'b1;
                    end else begin
                        rd_vld_reg <= 1'b0;
                        if (!rd_vld_reg) begin
                            state_reg <= ST_DECIDE;
                        end
                    end
                end
                ST_DECIDE: begin
                    travel_reg <= travel_next;
                    addr_reg   <= '0;
                    if (best_reg.have) begin
                        head_reg                <= best_reg.val;
                        marks_reg[best_idx_reg] <= 1'b1;
                        served_reg              <= served_reg + 1'b1;
                        out_cyl_reg             <= best_reg.val;
                        out_last_reg            <= (served_reg + 1'b1) == count_reg;
                        state_reg               <= ST_OUT;
                    end else begin
                        // Sweep turns at cylinder 0; circular scan jumps to the top.
                        head_reg  <= (policy_reg == POL_CSCAN) ? top_reg : '0;
                        phase_reg <= 1'b1;
                        state_reg <= ST_SCAN;
                    end
                    best_reg <= '0;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        if (out_last_reg) begin
                            count_reg  <= '0;
                            marks_reg  <= '0;
                            travel_reg <= '0;
                            state_reg  <= ST_IDLE;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid           = (state_reg == ST_OUT);
    assign m_served_cylinder = out_cyl_reg;
    assign m_total_travel    = travel_reg;
    assign m_last_served     = out_last_reg;

endmodule
